@@ sv/qrs_pkg.sv @@
// Shared types, widths and the saturation helper function of the quadratic root solver.
`timescale 1ns / 1ps
package qrs_pkg;

	// Square root: 34 result bits over a 68-bit radicand.
	localparam int SQ_W    = 34;
	localparam int SQ_RADW = 2 * SQ_W;
	localparam int SQ_RW   = SQ_W + 4;

	// Long division: 34-bit divisor, 33 quotient bits before saturation.
	localparam int DIV_DW = 34;
	localparam int DIV_QB = 33;

	typedef struct packed {
		logic [SQ_RADW-1:0] rad;
		logic [SQ_RW-1:0]   rem;
		logic [SQ_W-1:0]    root;
	} sqrt_slot_t;

	typedef struct packed {
		logic [DIV_DW-1:0] rem;
		logic [DIV_QB-1:0] low;
		logic [DIV_DW-1:0] dv;
		logic [DIV_QB-1:0] quo;
	} div_slot_t;

	typedef struct packed {
		logic        an;
		logic        bn;
		logic        cn;
		logic        dneg;
		logic [31:0] am;
		logic [31:0] bm;
		logic [31:0] cm;
	} qrs_side_t;

	typedef struct packed {
		logic dneg;
		logic use_a;
		logic use_c;
		logic neg_a;
		logic neg_c;
		logic ovf_a;
		logic ovf_c;
	} qrs_flag_t;

	// Sign and magnitude to a saturated 32-bit two's complement value.
	function automatic logic [31:0] qrs_sat(input logic neg, input logic ovf,
			input logic [DIV_QB-1:0] q);
		logic big;
		big = ovf | q[32] | q[31];
		if (big)
			qrs_sat = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else
			qrs_sat = neg ? (32'd0 - q[31:0]) : q[31:0];
	endfunction

endpackage

@@ sv/quadratic_root_solver.sv @@
// Pipelined quadratic root solver in the cancellation-free form.
//
//  channel | signals                      | contents
//  --------+------------------------------+-----------------------------------
//  s       | s_tvalid s_tready s_tdata[96] | coef_a, coef_b, coef_c
//  m       | m_tvalid m_tready m_tdata[72] | root_count, first_root, second_root
//
// One request enters per cycle unless a result waits at the output. The pipeline
// holds the 34-cell square root chain and the 33-cell divider chains. The whole
// pipeline advances together and halts only while a result waits at the output.
// Reset clears the valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
module quadratic_root_solver #(
	parameter int FRAC_BITS  = 16,
	parameter int TINY_SHIFT = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // coef_a, coef_b, coef_c
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata   // root_count, first_root, second_root, zero fill
);
	import qrs_pkg::*;

	localparam int NW     = 33 + FRAC_BITS;
	localparam int NSTAGE = 7 + SQ_W + DIV_QB;

	logic              en;
	logic [NSTAGE-1:0] vld_q;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[NSTAGE-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[NSTAGE-2:0], s_tvalid};
	end

	// Sign and magnitude split.
	qrs_side_t side_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.an   <= s_tdata[31];
			side_s1.bn   <= s_tdata[63];
			side_s1.cn   <= s_tdata[95];
			side_s1.dneg <= 1'b0;
			side_s1.am   <= s_tdata[31] ? (32'd0 - s_tdata[31:0]) : s_tdata[31:0];
			side_s1.bm   <= s_tdata[63] ? (32'd0 - s_tdata[63:32]) : s_tdata[63:32];
			side_s1.cm   <= s_tdata[95] ? (32'd0 - s_tdata[95:64]) : s_tdata[95:64];
		end
	end

	// Products b*b and a*c.
	qrs_side_t   side_s2;
	logic [63:0] bb_s2;
	logic [63:0] ac_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			bb_s2   <= side_s1.bm * side_s1.bm;
			ac_s2   <= side_s1.am * side_s1.cm;
		end
	end

	// Discriminant, kept exactly.
	logic [65:0] ac4;
	logic        same_sign;
	logic        dneg;
	qrs_side_t   side_d;
	assign ac4       = {ac_s2, 2'b00};
	assign same_sign = side_s2.an == side_s2.cn;
	assign dneg      = same_sign && (ac4 > {2'b00, bb_s2});

	always_comb begin
		side_d      = side_s2;
		side_d.dneg = dneg;
	end

	qrs_side_t   side_s3;
	logic [65:0] d_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_d;
			d_s3    <= same_sign ? ({2'b00, bb_s2} - ac4) : ({2'b00, bb_s2} + ac4);
		end
	end

	// Square root chain.
	sqrt_slot_t sq_slot [SQ_W+1];
	qrs_side_t  sq_side_q [SQ_W+1];

	assign sq_slot[0].rad  = {2'b00, d_s3};
	assign sq_slot[0].rem  = '0;
	assign sq_slot[0].root = '0;
	assign sq_side_q[0]    = side_s3;

	for (genvar i = 0; i < SQ_W; i++) begin : g_sqrt
		qrs_sqrt_cell u_cell (
			.clk  (clk),
			.en   (en),
			.din  (sq_slot[i]),
			.dout (sq_slot[i+1])
		);
		always_ff @(posedge clk) begin
			if (en)
				sq_side_q[i+1] <= sq_side_q[i];
		end
	end

	// 2q magnitude, root selection tests and dividends.
	qrs_side_t       side_e;
	logic [SQ_W-1:0] qm;
	assign side_e = sq_side_q[SQ_W];
	assign qm     = SQ_W'(side_e.bm) + sq_slot[SQ_W].root;

	qrs_flag_t         fl_p1;
	logic [NW-1:0]     na_p1;
	logic [NW-1:0]     nc_p1;
	logic [DIV_DW-1:0] da_p1;
	logic [DIV_DW-1:0] dc_p1;
	always_ff @(posedge clk) begin
		if (en) begin
			fl_p1.dneg  <= side_e.dneg;
			fl_p1.use_a <= !side_e.dneg && (SQ_W'(side_e.am) > (qm >> (TINY_SHIFT + 1)));
			fl_p1.use_c <= !side_e.dneg && (qm > SQ_W'(side_e.cm >> (TINY_SHIFT - 1)));
			fl_p1.neg_a <= side_e.bn == side_e.an;
			fl_p1.neg_c <= side_e.cn == side_e.bn;
			fl_p1.ovf_a <= 1'b0;
			fl_p1.ovf_c <= 1'b0;
			na_p1       <= side_e.dneg ? (NW'(side_e.bm) << (FRAC_BITS - 1))
			                           : (NW'(qm) << (FRAC_BITS - 1));
			nc_p1       <= NW'(side_e.cm) << (FRAC_BITS + 1);
			da_p1       <= DIV_DW'(side_e.am);
			dc_p1       <= qm;
		end
	end

	// Overflow precheck and divider set-up.
	qrs_flag_t fl_pre;
	always_comb begin
		fl_pre       = fl_p1;
		fl_pre.ovf_a = (na_p1 >> DIV_QB) >= NW'(da_p1);
		fl_pre.ovf_c = (nc_p1 >> DIV_QB) >= NW'(dc_p1);
	end

	qrs_flag_t fl_p2;
	div_slot_t dva_p2;
	div_slot_t dvc_p2;
	always_ff @(posedge clk) begin
		if (en) begin
			fl_p2       <= fl_pre;
			dva_p2.rem  <= DIV_DW'(na_p1 >> DIV_QB);
			dva_p2.low  <= na_p1[DIV_QB-1:0];
			dva_p2.dv   <= da_p1;
			dva_p2.quo  <= '0;
			dvc_p2.rem  <= DIV_DW'(nc_p1 >> DIV_QB);
			dvc_p2.low  <= nc_p1[DIV_QB-1:0];
			dvc_p2.dv   <= dc_p1;
			dvc_p2.quo  <= '0;
		end
	end

	// Two divider chains side by side: q/a (or the vertex) and c/q.
	div_slot_t dva [DIV_QB+1];
	div_slot_t dvc [DIV_QB+1];
	qrs_flag_t fl_q [DIV_QB+1];

	assign dva[0]  = dva_p2;
	assign dvc[0]  = dvc_p2;
	assign fl_q[0] = fl_p2;

	for (genvar j = 0; j < DIV_QB; j++) begin : g_div
		qrs_div_cell u_cell_a (
			.clk  (clk),
			.en   (en),
			.din  (dva[j]),
			.dout (dva[j+1])
		);
		qrs_div_cell u_cell_c (
			.clk  (clk),
			.en   (en),
			.din  (dvc[j]),
			.dout (dvc[j+1])
		);
		always_ff @(posedge clk) begin
			if (en)
				fl_q[j+1] <= fl_q[j];
		end
	end

	// Saturation.
	qrs_flag_t   fl_f1;
	logic [31:0] ra_f1;
	logic [31:0] rc_f1;
	always_ff @(posedge clk) begin
		if (en) begin
			fl_f1 <= fl_q[DIV_QB];
			ra_f1 <= qrs_sat(fl_q[DIV_QB].neg_a, fl_q[DIV_QB].ovf_a, dva[DIV_QB].quo);
			rc_f1 <= qrs_sat(fl_q[DIV_QB].neg_c, fl_q[DIV_QB].ovf_c, dvc[DIV_QB].quo);
		end
	end

	// Ordering and output register.
	logic        two;
	logic        swap;
	logic [1:0]  count;
	logic [31:0] first;
	logic [31:0] second;
	always_comb begin
		two   = fl_f1.use_a && fl_f1.use_c;
		swap  = two && ($signed(ra_f1) > $signed(rc_f1));
		count = {1'b0, fl_f1.use_a} + {1'b0, fl_f1.use_c};
		if (fl_f1.dneg || (fl_f1.use_a && !swap))
			first = ra_f1;
		else if (fl_f1.use_c)
			first = rc_f1;
		else
			first = '0;
		if (two)
			second = swap ? ra_f1 : rc_f1;
		else
			second = '0;
	end

	always_ff @(posedge clk) begin
		if (en)
			m_tdata <= {6'd0, second, first, count};
	end

endmodule

@@ sv/qrs_sqrt_cell.sv @@
// One restoring step of the integer square root, registered.
`timescale 1ns / 1ps
module qrs_sqrt_cell (
	input  logic               clk,
	input  logic               en,
	input  qrs_pkg::sqrt_slot_t din,
	output qrs_pkg::sqrt_slot_t dout
);
	import qrs_pkg::*;

	logic [SQ_RW-1:0] t;
	logic [SQ_RW-1:0] trial;
	logic             ge;

	always_comb begin
		t     = {din.rem[SQ_RW-3:0], din.rad[SQ_RADW-1 -: 2]};
		trial = {2'b00, din.root, 2'b01};
		ge    = t >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout.rad  <= {din.rad[SQ_RADW-3:0], 2'b00};
			dout.rem  <= ge ? (t - trial) : t;
			dout.root <= {din.root[SQ_W-2:0], ge};
		end
	end

endmodule

@@ sv/qrs_div_cell.sv @@
// One restoring step of unsigned long division, registered.
`timescale 1ns / 1ps
module qrs_div_cell (
	input  logic              clk,
	input  logic              en,
	input  qrs_pkg::div_slot_t din,
	output qrs_pkg::div_slot_t dout
);
	import qrs_pkg::*;

	logic [DIV_DW:0] t;
	logic [DIV_DW:0] diff;
	logic            ge;

	always_comb begin
		t    = {din.rem, din.low[DIV_QB-1]};
		diff = t - {1'b0, din.dv};
		ge   = t >= {1'b0, din.dv};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout.rem <= ge ? diff[DIV_DW-1:0] : t[DIV_DW-1:0];
			dout.low <= {din.low[DIV_QB-2:0], 1'b0};
			dout.dv  <= din.dv;
			dout.quo <= {din.quo[DIV_QB-2:0], ge};
		end
	end

endmodule
